### rtl/pal_pkg.sv
package pal_pkg;

    localparam int CAPACITY = 128;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CMP_W    = (CNT_W > 8) ? CNT_W : 8;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QFILL_W  = $clog2(QDEPTH + 1);

    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ADDR_W-1:0]  t_addr;
    typedef logic [CMP_W-1:0]   t_cmp;
    typedef logic [QPTR_W-1:0]  t_qptr;
    typedef logic [QFILL_W-1:0] t_qfill;

    localparam t_cnt   CAP_CNT    = t_cnt'(CAPACITY);
    localparam t_qptr  QPTR_LAST  = t_qptr'(QDEPTH - 1);
    localparam t_qfill QFILL_FULL = t_qfill'(QDEPTH);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [6:0]         found_index;
        logic signed [31:0] read_value;
        logic [7:0]         entry_count;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        t_kind              kind;
        t_status            status;
        t_addr              pos;
        logic signed [31:0] value;
        t_cnt               count_before;
        t_cnt               count_after;
    } t_cmd;

    function automatic t_cmp pos_to_cmp(input logic [7:0] p);
        return t_cmp'(p);
    endfunction

    function automatic t_addr pos_to_addr(input logic [7:0] p);
        t_cmp w;
        w = t_cmp'(p);
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] cnt_to_field(input t_cnt c);
        t_cmp w;
        w = t_cmp'(c);
        return w[7:0];
    endfunction

    function automatic logic [6:0] addr_to_field(input t_addr a);
        t_cmp w;
        w = t_cmp'(a);
        return w[6:0];
    endfunction

endpackage

### rtl/pal_front.sv
module pal_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pal_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_busy,
    output logic              o_push,
    output pal_pkg::t_cmd     o_cmd
);

    // count as it will stand once every queued item has executed
    pal_pkg::t_cnt    r_count;
    pal_pkg::t_cnt    n_count;
    pal_pkg::t_status n_status;
    pal_pkg::t_cmp    w_pos;
    pal_pkg::t_cmp    w_cnt;

    assign w_pos  = pal_pkg::pos_to_cmp(i_item.position);
    assign w_cnt  = pal_pkg::t_cmp'(r_count);
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        n_status = pal_pkg::ST_OK;
        n_count  = r_count;
        unique case (i_item.kind)
            pal_pkg::KIND_INSERT: begin
                if (r_count == pal_pkg::CAP_CNT) begin
                    n_status = pal_pkg::ST_FULL;
                end else if (w_pos > w_cnt) begin
                    n_status = pal_pkg::ST_BADPOS;
                end else begin
                    n_count = r_count + pal_pkg::t_cnt'(1);
                end
            end
            pal_pkg::KIND_DELETE: begin
                if (w_pos >= w_cnt) begin
                    n_status = pal_pkg::ST_BADPOS;
                end else begin
                    n_count = r_count - pal_pkg::t_cnt'(1);
                end
            end
            pal_pkg::KIND_SEARCH: begin
                n_status = pal_pkg::ST_OK;
            end
            pal_pkg::KIND_READ: begin
                if (w_pos >= w_cnt) begin
                    n_status = pal_pkg::ST_BADPOS;
                end
            end
            default: begin
                n_status = pal_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        o_cmd.kind         = i_item.kind;
        o_cmd.status       = n_status;
        o_cmd.pos          = pal_pkg::pos_to_addr(i_item.position);
        o_cmd.value        = i_item.value;
        o_cmd.count_before = r_count;
        o_cmd.count_after  = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pal_pkg::CAP_CNT)
        else $error("list count above capacity");

endmodule

### rtl/pal_queue.sv
module pal_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pal_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output pal_pkg::t_cmd o_head
);

    pal_pkg::t_cmd   r_slot [pal_pkg::QDEPTH];
    pal_pkg::t_qptr  r_wr_ptr;
    pal_pkg::t_qptr  r_rd_ptr;
    pal_pkg::t_qfill r_fill;

    assign o_full  = (r_fill == pal_pkg::QFILL_FULL);
    assign o_empty = (r_fill == '0);
    assign o_head  = r_slot[r_rd_ptr];

    function automatic pal_pkg::t_qptr bump(input pal_pkg::t_qptr p);
        return (p == pal_pkg::QPTR_LAST) ? '0 : p + pal_pkg::t_qptr'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + pal_pkg::t_qfill'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - pal_pkg::t_qfill'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

endmodule

### rtl/pal_back.sv
module pal_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  pal_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_strobe,
    output pal_pkg::t_out_item o_result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state             r_state, n_state;
    pal_pkg::t_cmd      r_cmd, n_cmd;
    pal_pkg::t_addr     r_raddr, n_raddr;
    pal_pkg::t_cnt      r_left, n_left;
    logic               r_pend, n_pend;
    pal_pkg::t_addr     r_pend_addr, n_pend_addr;
    logic signed [31:0] r_rd_val, n_rd_val;
    logic               r_strobe, n_strobe;
    pal_pkg::t_out_item r_out, n_out;

    logic signed [31:0] r_mem [pal_pkg::CAPACITY];
    logic signed [31:0] r_rdata;

    logic               w_we;
    pal_pkg::t_addr     w_waddr;
    logic signed [31:0] w_wdata;
    logic               w_ok;
    logic               w_hit;
    logic               w_finish;

    assign w_ok     = (r_cmd.status == pal_pkg::ST_OK);
    assign w_hit    = (r_state == S_RUN) && r_pend && w_ok
                      && (r_cmd.kind == pal_pkg::KIND_SEARCH) && (r_rdata == r_cmd.value);
    assign w_finish = (r_state == S_RUN) && (w_hit || (r_left == '0 && !r_pend));
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    // storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_raddr];
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_raddr     = r_raddr;
        n_left      = r_left;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_rd_val    = r_rd_val;
        n_strobe    = 1'b0;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_pend_addr;
        w_wdata     = r_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_cmd    = i_head;
                    n_rd_val = '0;
                    n_state  = S_RUN;
                    n_left   = '0;
                    n_raddr  = i_head.pos;
                    if (i_head.status == pal_pkg::ST_OK) begin
                        unique case (i_head.kind)
                            pal_pkg::KIND_INSERT: begin
                                n_left  = i_head.count_before - pal_pkg::t_cnt'(i_head.pos);
                                n_raddr = pal_pkg::t_addr'(i_head.count_before
                                          - pal_pkg::t_cnt'(1));
                            end
                            pal_pkg::KIND_DELETE: begin
                                n_left  = i_head.count_before - pal_pkg::t_cnt'(i_head.pos)
                                          - pal_pkg::t_cnt'(1);
                                n_raddr = i_head.pos + pal_pkg::t_addr'(1);
                            end
                            pal_pkg::KIND_SEARCH: begin
                                n_left  = i_head.count_before;
                                n_raddr = '0;
                            end
                            pal_pkg::KIND_READ: begin
                                n_left  = pal_pkg::t_cnt'(1);
                                n_raddr = i_head.pos;
                            end
                            default: begin
                                n_left = '0;
                            end
                        endcase
                    end
                end
            end
            S_RUN: begin
                // data read last cycle is ready: move it or test it
                if (r_pend) begin
                    unique case (r_cmd.kind)
                        pal_pkg::KIND_INSERT: begin
                            w_we    = 1'b1;
                            w_waddr = r_pend_addr + pal_pkg::t_addr'(1);
                        end
                        pal_pkg::KIND_DELETE: begin
                            w_we    = 1'b1;
                            w_waddr = r_pend_addr - pal_pkg::t_addr'(1);
                        end
                        pal_pkg::KIND_READ: begin
                            n_rd_val = r_rdata;
                        end
                        default: begin
                            w_we = 1'b0;
                        end
                    endcase
                end
                if (w_finish) begin
                    n_state  = S_IDLE;
                    n_strobe = 1'b1;
                    n_left   = '0;
                    n_out.status      = r_cmd.status;
                    n_out.found_index = '0;
                    n_out.read_value  = '0;
                    n_out.entry_count = pal_pkg::cnt_to_field(r_cmd.count_after);
                    if (r_cmd.kind == pal_pkg::KIND_SEARCH) begin
                        if (w_hit) begin
                            n_out.found_index = pal_pkg::addr_to_field(r_pend_addr);
                        end else begin
                            n_out.status = pal_pkg::ST_NOTFOUND;
                        end
                    end
                    if (r_cmd.kind == pal_pkg::KIND_READ && w_ok) begin
                        n_out.read_value = r_rd_val;
                    end
                    if (r_cmd.kind == pal_pkg::KIND_INSERT && w_ok) begin
                        w_we    = 1'b1;
                        w_waddr = r_cmd.pos;
                        w_wdata = r_cmd.value;
                    end
                end else if (r_left != '0) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_raddr;
                    n_left      = r_left - pal_pkg::t_cnt'(1);
                    if (r_cmd.kind == pal_pkg::KIND_INSERT) begin
                        n_raddr = r_raddr - pal_pkg::t_addr'(1);
                    end else begin
                        n_raddr = r_raddr + pal_pkg::t_addr'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_left   <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_raddr     <= n_raddr;
        r_pend_addr <= n_pend_addr;
        r_rd_val    <= n_rd_val;
        r_out       <= n_out;
    end

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("back-to-back result strobes");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("read in flight while idle");

    a_pop_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_RUN) && !r_strobe)
        else $error("popped item not started");

endmodule

### rtl/positional_array_list.sv
// Insert moves the entries from the position to the tail up by one, delete moves the
//   entries above the position down by one, search scans from entry 0 to the first
//   match, read fetches one entry; a rejected item touches no entry.
// The back runs one item at a time and walks the element store (one write port, one
//   read port) one entry per cycle. A two-item queue lets the front accept meanwhile.
// Reset (synchronous, i_rst_n low): count, queue and sequencer cleared; element
//   store keeps its contents. Results strobe one cycle; the receiver cannot stall.
module positional_array_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pal_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output pal_pkg::t_out_item o_result
);

    // front -> queue
    logic          w_push;
    pal_pkg::t_cmd w_cmd;
    // queue -> front and back
    logic          w_full;
    logic          w_empty;
    logic          w_pop;
    pal_pkg::t_cmd w_head;

    // front: checks each item against the projected count and tags a status
    pal_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_full  (w_full),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    // short queue of classified items between front and back
    pal_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // back: shifts, scans or reads the element store and forms the result
    pal_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

### tb/tb.sv
module tb;

    // Cycles without any accepted item or result before the run is declared hung.
    // Worst correct case is a full-list insert at 0 or a search miss plus the longest
    // driver gap, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 2000;
    // Settling time after the last result: longer than any single operation.
    localparam int DRAIN_CYCLES   = 160;
    localparam int RANDOM_ITEMS   = 1830;

    logic               i_clk;
    logic               i_rst_n;
    logic               start  = 1'b0;
    logic               busy;
    pal_pkg::t_in_item  i_item = '0;
    logic               o_strobe;
    pal_pkg::t_out_item o_result;

    positional_array_list uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Clock: period 4.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the list and its length.
    // ------------------------------------------------------------------
    logic signed [31:0] list_entries [pal_pkg::CAPACITY];
    int                 list_len = 0;

    pal_pkg::t_in_item  request_queue  [$];   // items waiting to be driven
    pal_pkg::t_out_item awaited_results[$];   // expected results, oldest first

    int  error_count = 0;
    int  idle_cycles = 0;
    bit  took        = 1'b0;         // item on the inputs was taken at the last edge
    int  gap_left    = 0;            // idle cycles still to insert before next item
    int  burst_left  = 0;            // items still to send back to back

    // Applies one request to the predicted list and returns the result item.
    function automatic pal_pkg::t_out_item apply_request(input pal_pkg::t_in_item req);
        pal_pkg::t_out_item res;
        int                 i;
        int                 p;
        res        = '0;
        res.status = pal_pkg::ST_OK;
        p          = int'(req.position);
        case (req.kind)
            pal_pkg::KIND_INSERT: begin
                // full check wins over the position check
                if (list_len >= pal_pkg::CAPACITY) begin
                    res.status = pal_pkg::ST_FULL;
                end else if (p > list_len) begin
                    res.status = pal_pkg::ST_BADPOS;
                end else begin
                    for (i = list_len; i > p; i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[p] = req.value;
                    list_len++;
                end
            end
            pal_pkg::KIND_DELETE: begin
                if (p >= list_len) begin
                    res.status = pal_pkg::ST_BADPOS;
                end else begin
                    for (i = p; i + 1 < list_len; i++)
                        list_entries[i] = list_entries[i+1];
                    list_len--;
                end
            end
            pal_pkg::KIND_SEARCH: begin
                // lowest matching index wins
                res.status = pal_pkg::ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (res.status == pal_pkg::ST_NOTFOUND
                        && list_entries[i] == req.value) begin
                        res.status      = pal_pkg::ST_OK;
                        res.found_index = 7'(i);
                    end
                end
            end
            pal_pkg::KIND_READ: begin
                if (p >= list_len)
                    res.status = pal_pkg::ST_BADPOS;
                else
                    res.read_value = list_entries[p];
            end
        endcase
        res.entry_count = 8'(list_len);
        return res;
    endfunction

    // Length of the list after a request; lets the generator aim positions.
    function automatic int count_after(input pal_pkg::t_in_item req, input int cnt);
        if (req.kind == pal_pkg::KIND_INSERT && cnt < pal_pkg::CAPACITY
            && int'(req.position) <= cnt)
            return cnt + 1;
        if (req.kind == pal_pkg::KIND_DELETE && int'(req.position) < cnt)
            return cnt - 1;
        return cnt;
    endfunction

    function automatic pal_pkg::t_in_item make_item(input pal_pkg::t_kind k, input int p,
                                                    input logic [31:0] v);
        pal_pkg::t_in_item it;
        it.kind     = k;
        it.position = 8'(p);
        it.value    = v;
        return it;
    endfunction

    // Idle time before the next item: mostly none or short, a few long,
    // and now and then a burst of back-to-back items.
    function automatic int next_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: inputs move on the falling edge only. A held item stays put
    // until it is taken; after that either the next item or a gap follows.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (request_queue.size() > 0) begin
                i_item   <= request_queue.pop_front();
                start    <= 1'b1;
                gap_left <= next_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor, predictor and watchdog on the rising edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        pal_pkg::t_out_item exp_r;
        took <= i_rst_n && start && !busy;

        if (!i_rst_n) begin
            list_len = 0;
        end else begin
            // result side: compare with oldest expectation
            if (o_strobe) begin
                if (awaited_results.size() == 0) begin
                    $error("result with nothing expected: status %0d count %0d",
                           o_result.status, o_result.entry_count);
                    error_count++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(o_result.status));
                    check_field("found_index", 32'(exp_r.found_index),
                                32'(o_result.found_index));
                    check_field("read_value", exp_r.read_value, o_result.read_value);
                    check_field("entry_count", 32'(exp_r.entry_count),
                                32'(o_result.entry_count));
                end
            end
            // request side: predict at the edge that takes the item
            if (start && !busy)
                awaited_results.push_back(apply_request(i_item));
        end

        if ((i_rst_n && start && !busy) || o_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    logic signed [31:0] value_pool [8];

    // Values half the time from a small pool so searches hit and duplicates occur.
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    initial begin
        pal_pkg::t_in_item req;
        int                shadow_len;
        bit                filling;
        int                roll;
        int                n;

        i_rst_n = 1'b0;

        value_pool[0] = 32'sh7FFFFFFF;
        value_pool[1] = 32'sh80000000;
        value_pool[2] = 0;
        value_pool[3] = -1;
        for (n = 4; n < 8; n++)
            value_pool[n] = $urandom;

        // Directed part: empty-list refusals, extremes, first-match search,
        // edge deletes and out-of-range positions.
        request_queue.push_back(make_item(pal_pkg::KIND_READ,   0, 0));     // read empty
        request_queue.push_back(make_item(pal_pkg::KIND_DELETE, 0, 0));     // delete empty
        request_queue.push_back(make_item(pal_pkg::KIND_SEARCH, 0, 0));     // miss on empty
        request_queue.push_back(make_item(pal_pkg::KIND_INSERT, 1, 5));     // beyond count
        request_queue.push_back(make_item(pal_pkg::KIND_INSERT, 0, 32'h7FFFFFFF));
        request_queue.push_back(make_item(pal_pkg::KIND_INSERT, 1, 32'h80000000)); // append
        request_queue.push_back(make_item(pal_pkg::KIND_INSERT, 0, 32'hFFFFFFFF)); // at head
        request_queue.push_back(make_item(pal_pkg::KIND_INSERT, 1, 0));     // middle
        request_queue.push_back(make_item(pal_pkg::KIND_INSERT, 255, 7));   // top position
        for (n = 0; n < 4; n++)
            request_queue.push_back(make_item(pal_pkg::KIND_READ, n, 0));
        request_queue.push_back(make_item(pal_pkg::KIND_READ,   4, 0));     // read at count
        request_queue.push_back(make_item(pal_pkg::KIND_READ,   255, 0));
        request_queue.push_back(make_item(pal_pkg::KIND_SEARCH, 0, 32'h80000000)); // last
        request_queue.push_back(make_item(pal_pkg::KIND_SEARCH, 0, 12345)); // miss
        request_queue.push_back(make_item(pal_pkg::KIND_INSERT, 2, 32'h7FFFFFFF)); // dup
        request_queue.push_back(make_item(pal_pkg::KIND_SEARCH, 0, 32'h7FFFFFFF)); // first
        request_queue.push_back(make_item(pal_pkg::KIND_DELETE, 4, 0));     // tail
        request_queue.push_back(make_item(pal_pkg::KIND_DELETE, 0, 0));     // head
        request_queue.push_back(make_item(pal_pkg::KIND_DELETE, 5, 0));     // beyond count
        request_queue.push_back(make_item(pal_pkg::KIND_DELETE, 255, 0));
        request_queue.push_back(make_item(pal_pkg::KIND_READ,   1, 0));
        shadow_len = 0;
        foreach (request_queue[k])
            shadow_len = count_after(request_queue[k], shadow_len);

        // Random part: alternate fill and drain sweeps so the list runs from
        // empty to full and back, with searches, reads and noise mixed in.
        filling = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                if (filling)
                    req = make_item(pal_pkg::KIND_INSERT, $urandom_range(0, shadow_len),
                                    pick_value());
                else
                    req = make_item(pal_pkg::KIND_DELETE,
                                    shadow_len == 0 ? 0 : $urandom_range(0, shadow_len - 1),
                                    pick_value());
            end else if (roll < 82) begin
                req = make_item(pal_pkg::KIND_SEARCH, $urandom_range(0, 255), pick_value());
            end else if (roll < 94) begin
                req = make_item(pal_pkg::KIND_READ,
                                shadow_len == 0 ? 0 : $urandom_range(0, shadow_len - 1),
                                $urandom);
            end else begin
                // noise: any kind, any position, any value
                req = make_item(pal_pkg::t_kind'($urandom_range(0, 3)),
                                $urandom_range(0, 255), $urandom);
            end
            request_queue.push_back(req);
            shadow_len = count_after(req, shadow_len);
            // turn around at the ends after a few refused requests there,
            // and now and then part way
            if (filling && shadow_len == pal_pkg::CAPACITY && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && shadow_len == 0 && $urandom_range(0, 3) == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 199) == 0)
                filling = !filling;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_queue.size() != 0 || start)
            @(negedge i_clk);
        while (awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
